/* rtl/sha_pkg.sv */
package sha_pkg;

	localparam int WordW = 32;
	localparam int BlockWords = 16;
	localparam int Rounds = 64;
	localparam int DigestWords = 8;
	localparam logic [WordW-1:0] PadWord = 32'h8000_0000;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_OUT
	} state_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0: r = 32'h6A09E667;
			3'd1: r = 32'hBB67AE85;
			3'd2: r = 32'h3C6EF372;
			3'd3: r = 32'hA54FF53A;
			3'd4: r = 32'h510E527F;
			3'd5: r = 32'h9B05688C;
			3'd6: r = 32'h1F83D9AB;
			default: r = 32'h5BE0CD19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] t);
		word_t r;
		case (t)
			6'd0: r = 32'h428A2F98; 6'd1: r = 32'h71374491;
			6'd2: r = 32'hB5C0FBCF; 6'd3: r = 32'hE9B5DBA5;
			6'd4: r = 32'h3956C25B; 6'd5: r = 32'h59F111F1;
			6'd6: r = 32'h923F82A4; 6'd7: r = 32'hAB1C5ED5;
			6'd8: r = 32'hD807AA98; 6'd9: r = 32'h12835B01;
			6'd10: r = 32'h243185BE; 6'd11: r = 32'h550C7DC3;
			6'd12: r = 32'h72BE5D74; 6'd13: r = 32'h80DEB1FE;
			6'd14: r = 32'h9BDC06A7; 6'd15: r = 32'hC19BF174;
			6'd16: r = 32'hE49B69C1; 6'd17: r = 32'hEFBE4786;
			6'd18: r = 32'h0FC19DC6; 6'd19: r = 32'h240CA1CC;
			6'd20: r = 32'h2DE92C6F; 6'd21: r = 32'h4A7484AA;
			6'd22: r = 32'h5CB0A9DC; 6'd23: r = 32'h76F988DA;
			6'd24: r = 32'h983E5152; 6'd25: r = 32'hA831C66D;
			6'd26: r = 32'hB00327C8; 6'd27: r = 32'hBF597FC7;
			6'd28: r = 32'hC6E00BF3; 6'd29: r = 32'hD5A79147;
			6'd30: r = 32'h06CA6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27B70A85; 6'd33: r = 32'h2E1B2138;
			6'd34: r = 32'h4D2C6DFC; 6'd35: r = 32'h53380D13;
			6'd36: r = 32'h650A7354; 6'd37: r = 32'h766A0ABB;
			6'd38: r = 32'h81C2C92E; 6'd39: r = 32'h92722C85;
			6'd40: r = 32'hA2BFE8A1; 6'd41: r = 32'hA81A664B;
			6'd42: r = 32'hC24B8B70; 6'd43: r = 32'hC76C51A3;
			6'd44: r = 32'hD192E819; 6'd45: r = 32'hD6990624;
			6'd46: r = 32'hF40E3585; 6'd47: r = 32'h106AA070;
			6'd48: r = 32'h19A4C116; 6'd49: r = 32'h1E376C08;
			6'd50: r = 32'h2748774C; 6'd51: r = 32'h34B0BCB5;
			6'd52: r = 32'h391C0CB3; 6'd53: r = 32'h4ED8AA4A;
			6'd54: r = 32'h5B9CCA4F; 6'd55: r = 32'h682E6FF3;
			6'd56: r = 32'h748F82EE; 6'd57: r = 32'h78A5636F;
			6'd58: r = 32'h84C87814; 6'd59: r = 32'h8CC70208;
			6'd60: r = 32'h90BEFFFA; 6'd61: r = 32'hA4506CEB;
			6'd62: r = 32'hBEF9A3F7;
			default: r = 32'hC67178F2;
		endcase
		return r;
	endfunction

endpackage

/* rtl/sha_if.sv */
interface sha_in_if;
	logic valid;
	logic ready;
	logic [31:0] message_word;
	logic final_word;
	modport source (output valid, output message_word, output final_word, input ready);
	modport sink (input valid, input message_word, input final_word, output ready);
endinterface

interface sha_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [2:0] digest_index;
	logic digest_end;
	modport source (output valid, output digest_word, output digest_index, output digest_end,
		input ready);
	modport sink (input valid, input digest_word, input digest_index, input digest_end,
		output ready);
endinterface

/* rtl/sha_round.sv */
// One compression round on the working variables; schedule word given.
module sha_round
	import sha_pkg::*;
(
	input  word_t [7:0] v,
	input  word_t       w,
	input  word_t       k,
	output word_t [7:0] v_next
);
	word_t s1, ch, s0, maj, t1, t2;

	always_comb begin
		s1 = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
		ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
		s0 = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
		maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
		t1 = v[7] + s1 + ch + k + w;
		t2 = s0 + maj;
		v_next[7] = v[6];
		v_next[6] = v[5];
		v_next[5] = v[4];
		v_next[4] = v[3] + t1;
		v_next[3] = v[2];
		v_next[2] = v[1];
		v_next[1] = v[0];
		v_next[0] = t1 + t2;
	end
endmodule

/* rtl/sha_sched.sv */
// Message schedule expansion for one new word.
module sha_sched
	import sha_pkg::*;
(
	input  word_t w16,
	input  word_t w15,
	input  word_t w7,
	input  word_t w2,
	output word_t w_new
);
	word_t s0, s1;

	always_comb begin
		s0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		s1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		w_new = s1 + w7 + s0 + w16;
	end
endmodule

/* rtl/sha256_word_stream_hash.sv */
// Channel  Role  Payload
// in       sink  message_word[31:0], final_word
// out      src   digest_word[31:0], digest_index[2:0], digest_end
//
// A word is taken only while idle; the 16th word of a block starts a compression (load the
// window, 64 rounds, the chaining add). A final word adds a padding pass from the first pad
// slot plus a compression, a second padded block when the length does not fit, and eight
// digest words on the output.
// Reset clears control state and the byte count and loads the IV into the chaining registers.
// The input is not ready while a block pads, compresses or the digest drains.
module sha256_word_stream_hash
	import sha_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha_in_if.sink   in_ch,
	sha_out_if.source out_ch
);
	state_t state_q, state_d;

	// block memory (message buffer, swept into the schedule window)
	word_t blk_mem [BlockWords];
	// chaining values held in registers
	word_t [7:0] cv_q;
	word_t [7:0] v_q;
	word_t [15:0] win_q;
	logic [63:0] count_q;
	logic [6:0] t_q;
	logic last_q;
	logic [4:0] pad_q;
	logic two_q;
	logic tail_q;
	logic [3:0] oi_q;

	word_t [7:0] v_next;
	word_t w_cur, w_exp;
	logic [3:0] slot;
	logic [63:0] bits;

	assign slot = count_q[5:2];
	assign bits = {count_q[60:0], 3'b000};

	sha_sched u_sched (.w16(win_q[0]), .w15(win_q[1]), .w7(win_q[9]), .w2(win_q[14]),
		.w_new(w_exp));
	assign w_cur = (t_q[5:0] < 6'd16 && t_q[6] == 1'b0) ? win_q[0] : w_exp;
	sha_round u_round (.v(v_q), .w(w_cur), .k(round_k(t_q[5:0])), .v_next(v_next));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && in_ch.ready) begin
					if (slot == 4'd15) state_d = ST_LOAD;
					else if (in_ch.final_word) state_d = ST_PAD;
				end
			end
			ST_PAD: if (pad_q[4]) state_d = ST_LOAD;
			ST_LOAD: if (t_q[4]) state_d = ST_ROUND;
			ST_ROUND: if (t_q == 7'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (!last_q) state_d = ST_IDLE;
				else if (two_q || tail_q) state_d = ST_PAD;
				else state_d = ST_OUT;
			end
			ST_OUT: if (out_ch.ready && oi_q == 4'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_OUT);
		out_ch.digest_word = cv_q[oi_q[2:0]];
		out_ch.digest_index = oi_q[2:0];
		out_ch.digest_end = (oi_q == 4'd7);
	end

	// block memory writes and padding fill
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid)
			blk_mem[slot] <= in_ch.message_word;
		else if (state_q == ST_PAD && !pad_q[4])
			blk_mem[pad_q[3:0]] <= (pad_q[3:0] == slot && !two_q) ? PadWord :
				(pad_q[3:0] == 4'd14 && !(slot >= 4'd14 && !two_q)) ? bits[63:32] :
				(pad_q[3:0] == 4'd15 && !(slot >= 4'd14 && !two_q)) ? bits[31:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			t_q <= '0;
			last_q <= 1'b0;
			pad_q <= '0;
			two_q <= 1'b0;
			tail_q <= 1'b0;
			oi_q <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					t_q <= '0;
					pad_q <= (in_ch.valid && in_ch.final_word && slot != 4'd15) ?
						{1'b0, slot + 4'd1} : 5'd0;
					if (in_ch.valid) begin
						count_q <= count_q + 64'd4;
						last_q <= in_ch.final_word;
						two_q <= 1'b0;
						// a final word in the last slot leaves a whole pad block to build
						tail_q <= in_ch.final_word && slot == 4'd15;
					end
				end
				ST_PAD: begin
					// fill from the slot after the final word (or from 0 on a second block)
					tail_q <= 1'b0;
					if (pad_q[4]) begin
						t_q <= '0;
						two_q <= two_q ? 1'b0 : (slot >= 4'd14);
					end else if (pad_q[3:0] == 4'd15) pad_q <= 5'h10;
					else pad_q <= pad_q + 5'd1;
				end
				ST_LOAD: begin
					// sweep the block memory into the window
					if (!t_q[4]) begin
						win_q[t_q[3:0]] <= blk_mem[t_q[3:0]];
						t_q <= t_q + 7'd1;
					end else t_q <= '0;
					v_q <= cv_q;
				end
				ST_ROUND: begin
					v_q <= v_next;
					t_q <= t_q + 7'd1;
					if (t_q >= 7'd16 || t_q[6]) begin
						for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
						win_q[15] <= w_exp;
					end else begin
						for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
						win_q[15] <= win_q[0];
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
					oi_q <= '0;
					pad_q <= '0;
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						oi_q <= oi_q + 4'd1;
						if (oi_q == 4'd7) begin
							for (int i = 0; i < 8; i++) cv_q[i] <= iv_word(3'(i));
							count_q <= '0;
							last_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
